// File: src/sbusfd_pkg.sv
// Shared types, constants and helpers for the SBUS frame decoder.
package sbusfd_pkg;

    localparam int unsigned NUM_CELLS = 22;
    localparam int unsigned NUM_CH    = 16;
    localparam int unsigned RAW_W     = 11;
    localparam int unsigned OFF_W     = 11;
    localparam int unsigned LIM_W     = 10;
    localparam int unsigned POS_W     = 5;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE = 8'h00;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_IDLE   = 5'd0;
    localparam logic [POS_W-1:0] POS_DATA0  = 5'd1;
    localparam logic [POS_W-1:0] POS_DATAN  = 5'd22;
    localparam logic [POS_W-1:0] POS_FLAGS  = 5'd23;
    localparam logic [POS_W-1:0] POS_FOOTER = 5'd24;
    localparam logic [POS_W-1:0] POS_DONE   = 5'd25;

    // configuration register indexes
    localparam logic CFG_CENTER = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    // switch codes
    localparam logic [1:0] SW_DOWN = 2'd1;
    localparam logic [1:0] SW_UP   = 2'd2;
    localparam logic [1:0] SW_MID  = 2'd3;

    typedef struct packed {
        logic shift1;   // take byte from neighbour above
        logic shift2;   // take byte from two cells above
    } t_cell_ctl;

    function automatic logic [1:0] map_switch(input logic [1:0] code);
        logic [1:0] res;
        unique case (code)
            2'd0:    res = SW_DOWN;
            2'd1:    res = SW_UP;
            default: res = SW_MID;
        endcase
        return res;
    endfunction

endpackage

// File: src/sbusfd_cell.sv
// One byte cell of the frame store chain.
module sbusfd_cell (
    input  logic                 i_clk,
    input  sbusfd_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]           i_next1,
    input  logic [7:0]           i_next2,
    output logic [7:0]           o_byte
);
    import sbusfd_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift2) begin
            n_byte = i_next2;
        end else if (i_ctl.shift1) begin
            n_byte = i_next1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// File: src/sbusfd_scale.sv
// Channel extraction from the bottom cells, offset subtraction and clamp.
module sbusfd_scale (
    input  logic [23:0]                      i_window,
    input  logic [2:0]                       i_bit_off,
    input  logic [sbusfd_pkg::OFF_W-1:0]     i_center,
    input  logic [sbusfd_pkg::LIM_W-1:0]     i_limit,
    output logic signed [sbusfd_pkg::RAW_W-1:0] o_value
);
    import sbusfd_pkg::*;

    logic [23:0]        w_shifted;
    logic [RAW_W-1:0]   w_raw;
    logic signed [11:0] w_diff;
    logic signed [11:0] w_lim;
    logic signed [11:0] w_clamped;

    always_comb begin
        w_shifted = i_window >> i_bit_off;
        w_raw     = w_shifted[RAW_W-1:0];
        w_diff    = signed'({1'b0, i_center}) - signed'({1'b0, w_raw});
        w_lim     = signed'({2'b00, i_limit});
        if (w_diff > w_lim) begin
            w_clamped = w_lim;
        end else if (w_diff < -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = w_diff;
        end
        o_value = w_clamped[RAW_W-1:0];
    end

endmodule

// File: src/sbus_frame_decoder.sv
// SBUS frame decoder: byte cell chain, frame control and channel output.
// A good footer word sets r_emit; the first channel word then goes through the output register.
// Throughput: one input word per cycle while loading; after a good frame the
//   16 channel words leave one per cycle while the receiver is ready (the cell
//   chain shifts one or two bytes per channel), and the input stalls while they are produced.
// Reset (i_rst_n low, synchronous): frame position, header flag, emit and
//   output valid cleared; centre offset 1024, clamp limit 660.
module sbus_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    // channel words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                        // [16:15] switch_one, [18:17] switch_two,
                                        // [26:19] frame_flags, [31:27] zero
    output logic        m_axis_tlast,   // last_of_frame
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [10:0] i_cfg_data
);
    import sbusfd_pkg::*;

    // configuration registers
    logic [OFF_W-1:0] r_center;
    logic [LIM_W-1:0] r_limit;

    // frame control
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_hdr;
    logic             n_hdr;
    logic [7:0]       r_flags;
    logic             r_emit;
    logic             n_emit;
    logic [3:0]       r_ch;
    logic [2:0]       r_boff;   // bit offset of current channel in cell 0

    // output register
    logic                    r_out_valid;
    logic [3:0]              r_out_ch;
    logic signed [RAW_W-1:0] r_out_val;
    logic [7:0]              r_out_flags;
    logic                    r_out_last;

    logic                    w_acc;
    logic                    w_load;
    logic                    w_fire;
    logic                    w_adv1;
    logic                    w_adv2;
    logic                    w_emit_go;
    t_cell_ctl               w_ctl;
    logic [7:0]              w_cell [NUM_CELLS];
    logic signed [RAW_W-1:0] w_value;

    assign s_axis_tready = !r_emit;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_fire = r_emit && (!r_out_valid || m_axis_tready);

    // channel at bit offset >= 5: the next channel starts in the third cell, so move two bytes on
    assign w_adv2 = w_fire && (r_boff >= 3'd5);
    assign w_adv1 = w_fire && (r_boff < 3'd5);

    always_comb begin
        n_pos     = r_pos;
        n_hdr     = r_hdr;
        w_load    = 1'b0;
        w_emit_go = 1'b0;
        if (w_acc) begin
            if (s_axis_tuser) begin
                n_hdr = (s_axis_tdata == HEADER_BYTE);
                n_pos = POS_DATA0;
            end else if (r_pos >= POS_DATA0 && r_pos <= POS_DATAN) begin
                w_load = 1'b1;
                n_pos  = r_pos + 5'd1;
            end else if (r_pos == POS_FLAGS) begin
                n_pos = POS_FOOTER;
            end else if (r_pos == POS_FOOTER) begin
                n_pos     = POS_DONE;
                w_emit_go = r_hdr && (s_axis_tdata == FOOTER_BYTE);
            end
        end
        n_emit = r_emit;
        if (w_emit_go) begin
            n_emit = 1'b1;
        end else if (w_fire && r_ch == 4'(NUM_CH - 1)) begin
            n_emit = 1'b0;
        end
        w_ctl.shift1 = w_load || w_adv1;
        w_ctl.shift2 = w_adv2;
    end

    // cell chain: data bytes enter at the top cell, byte 1 ends in cell 0
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        logic [7:0] w_n1;
        logic [7:0] w_n2;
        if (k == NUM_CELLS - 1) begin : g_top
            assign w_n1 = s_axis_tdata;
            assign w_n2 = 8'h00;
        end else if (k == NUM_CELLS - 2) begin : g_sub
            assign w_n1 = w_cell[k+1];
            assign w_n2 = 8'h00;
        end else begin : g_mid
            assign w_n1 = w_cell[k+1];
            assign w_n2 = w_cell[k+2];
        end
        sbusfd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_next1 (w_n1),
            .i_next2 (w_n2),
            .o_byte  (w_cell[k])
        );
    end

    sbusfd_scale u_scale (
        .i_window  ({w_cell[2], w_cell[1], w_cell[0]}),
        .i_bit_off (r_boff),
        .i_center  (r_center),
        .i_limit   (r_limit),
        .o_value   (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center    <= OFF_W'(1024);
            r_limit     <= LIM_W'(660);
            r_pos       <= POS_IDLE;
            r_hdr       <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CENTER: r_center <= i_cfg_data;
                    CFG_LIMIT:  r_limit  <= i_cfg_data[LIM_W-1:0];
                    default:    ;
                endcase
            end
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_emit <= n_emit;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and channel walk: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_acc && !s_axis_tuser && r_pos == POS_FLAGS) begin
            r_flags <= s_axis_tdata;
        end
        if (w_emit_go) begin
            r_ch   <= 4'd0;
            r_boff <= 3'd0;
        end else if (w_fire) begin
            r_ch   <= r_ch + 4'd1;
            // 11 bits on: one byte plus 3, or two bytes minus 5
            r_boff <= w_adv2 ? (r_boff - 3'd5) : (r_boff + 3'd3);
        end
        if (w_fire) begin
            r_out_ch    <= r_ch;
            r_out_val   <= w_value;
            r_out_flags <= r_flags;
            r_out_last  <= (r_ch == 4'(NUM_CH - 1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'b00000, r_out_flags,
                            map_switch(r_out_flags[3:2]),
                            map_switch(r_out_flags[1:0]),
                            r_out_val, r_out_ch};

`ifndef ASSERT_OFF
    // no input taken while channel words are being produced
    a_no_input_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> !s_axis_tready)
        else $error("input accepted during channel output");

    // the last channel closes the emit phase
    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_ch == 4'(NUM_CH - 1)) |=> !r_emit)
        else $error("emit phase did not end after last channel");

    // tlast only with channel fifteen
    a_last_is_ch15: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] == 4'hF))
        else $error("tlast on wrong channel");

    // emit starts only on a footer word with a good header
    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_emit) |-> ($past(r_pos) == POS_FOOTER && $past(r_hdr)))
        else $error("emit started outside a good footer");
`endif

endmodule

// File: sim/sbus_frame_decoder_tb.sv
// Self-checking bench for the SBUS frame decoder: directed frames, then random frames.
`timescale 1ns / 1ps

module sbus_frame_decoder_tb;
    import sbusfd_pkg::*;

    // no handshake on either side for this long means the block has hung
    localparam int WD_LIMIT      = 2000;
    // quiet cycles before a register write and at the end: footer latency plus
    // the sixteen channel words, with margin
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 160;
    localparam int REPORT_MAX    = 10;

    // one channel word as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  flags;
        logic [1:0]  sw2;
        logic [1:0]  sw1;
        logic [10:0] value;
        logic [3:0]  chan;
    } t_chan_word;

    typedef struct packed {
        logic       last;
        t_chan_word word;
    } t_chan_exp;

    typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND} t_fill;

    // one directed frame; the typed fields hold the result where it is obvious
    typedef struct {
        bit          set_cfg;
        logic [10:0] centre;
        logic [9:0]  limit;
        int          pre;       // loose words before the header
        logic [7:0]  hdr;
        t_fill       fill;
        logic [7:0]  flags;
        logic [7:0]  ftr;
        int          cut;       // words of the frame sent, 25 = whole frame
        int          post;      // loose words after the frame
        bit          typed;
        int          n_out;
        logic signed [10:0] val;
        logic [1:0]  sw1;
        logic [1:0]  sw2;
    } t_frame_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] rx_byte
    logic        s_axis_tuser = 1'b0;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [3:0] channel_index, [14:4] channel_value,
                                        // [16:15] switch_one, [18:17] switch_two,
                                        // [26:19] frame_flags, [31:27] zero
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_CENTER;
    logic [10:0] i_cfg_data = '0;

    sbus_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Decoder predictor: own copy of frame position, header flag,
    // byte store and registers
    // ---------------------------------------------------------------
    logic [4:0]  frm_pos = POS_IDLE;
    logic        hdr_ok = 1'b0;
    logic [7:0]  frm_bytes [0:NUM_CELLS] = '{default: 8'h00};  // 22 data + flag byte
    logic [10:0] centre_reg = 11'd1024;
    logic [9:0]  limit_reg = 10'd660;

    t_chan_exp   chan_words_due [$];
    int          bad_words = 0;
    int          words_sent = 0;
    int          burst_left = 0;
    logic [7:0]  body [0:NUM_CELLS-1];

    function automatic logic [1:0] switch_code(input logic [1:0] bits);
        if (bits == 2'b00)
            return SW_DOWN;
        else if (bits == 2'b01)
            return SW_UP;
        return SW_MID;
    endfunction

    // Advance the predictor by one accepted word; a good footer queues the
    // sixteen channel words when keep is set.
    function automatic void decode_step(input logic [7:0] b, input logic st, input bit keep);
        t_chan_exp   r;
        logic [10:0] raw;
        logic [7:0]  fl;
        int          bitn;
        int          v;
        int          lim;
        if (st) begin
            // a start always opens a new frame, whatever was in progress
            hdr_ok = (b == HEADER_BYTE);
            frm_pos = POS_DATA0;
            return;
        end
        // idle after reset, or past the footer: word ignored
        if (frm_pos == POS_IDLE || frm_pos >= POS_DONE)
            return;
        if (frm_pos < POS_FOOTER) begin
            frm_bytes[int'(frm_pos) - 1] = b;
            frm_pos = frm_pos + 5'd1;
            return;
        end
        frm_pos = POS_DONE;
        if (!hdr_ok || b != FOOTER_BYTE || !keep)
            return;
        fl = frm_bytes[NUM_CELLS];
        lim = int'(limit_reg);
        for (int c = 0; c < NUM_CH; c++) begin
            // channels packed LSB first across the 22 data bytes
            for (int k = 0; k < RAW_W; k++) begin
                bitn = c * RAW_W + k;
                raw[k] = frm_bytes[(bitn / 8) % NUM_CELLS][bitn % 8];
            end
            v = int'(centre_reg) - int'(raw);
            if (v > lim)
                v = lim;
            else if (v < -lim)
                v = -lim;
            r = '0;
            r.last = (c == NUM_CH - 1);
            r.word.chan = 4'(c);
            r.word.value = 11'(v);
            r.word.sw1 = switch_code(fl[1:0]);
            r.word.sw2 = switch_code(fl[3:2]);
            r.word.flags = fl;
            chan_words_due.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ---------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic st, input bit keep);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        words_sent++;
        decode_step(b, st, keep);
    endtask

    // loose words without a start
    task automatic send_noise(input int n);
        repeat (n) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void fill_body(input t_fill f);
        for (int i = 0; i < NUM_CELLS; i++)
            body[i] = (f == FILL_ZERO) ? 8'h00 : (f == FILL_ONES) ? 8'hFF : rand_data();
    endfunction

    // header, 22 data words, flag word, footer; stops after cut words
    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] fl,
                              input logic [7:0] ftr, input int cut, input bit keep);
        for (int i = 0; i < cut; i++) begin
            if (i == 0)
                send_word(hdr, 1'b1, keep);
            else if (i <= NUM_CELLS)
                send_word(body[i-1], 1'b0, keep);
            else if (i == NUM_CELLS + 1)
                send_word(fl, 1'b0, keep);
            else
                send_word(ftr, 1'b0, keep);
        end
    endtask

    // drop valid, let every due word come out, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        for (int k = 0; k < 4 * WD_LIMIT && chan_words_due.size() != 0; k++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [10:0] centre, input logic [9:0] limit);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CENTER;
        i_cfg_data <= centre;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIMIT;
        i_cfg_data <= {1'b0, limit};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        centre_reg = centre;
        limit_reg  = limit;
    endtask

    // ---------------------------------------------------------------
    // Receiver: rotating ready pattern, renewed on each wrap of pat_age, which counts cycles
    // ---------------------------------------------------------------
    logic [7:0] rdy_pat = 8'hFF;
    logic [5:0] pat_age = '0;

    always @(posedge i_clk) begin
        pat_age <= pat_age + 6'd1;
        if (pat_age == 6'd63) begin
            rdy_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end else begin
            rdy_pat <= {rdy_pat[0], rdy_pat[7:1]};
        end
        m_axis_tready <= rdy_pat[0];
    end

    // ---------------------------------------------------------------
    // Channel word checker
    // ---------------------------------------------------------------
    t_chan_exp  want;
    t_chan_word got;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (chan_words_due.size() == 0) begin
                bad_words++;
                if (bad_words <= REPORT_MAX)
                    $display("%0t: unexpected channel word ch=%0d val=%0d last=%b",
                             $realtime, got.chan, $signed(got.value), m_axis_tlast);
            end else begin
                want = chan_words_due.pop_front();
                if (got.chan !== want.word.chan || got.value !== want.word.value ||
                    got.sw1 !== want.word.sw1 || got.sw2 !== want.word.sw2 ||
                    got.flags !== want.word.flags || got.pad !== want.word.pad ||
                    m_axis_tlast !== want.last) begin
                    bad_words++;
                    if (bad_words <= REPORT_MAX)
                        $display({"%0t: mismatch exp ch=%0d val=%0d sw=%0d/%0d fl=%h last=%b",
                                  " got ch=%0d val=%0d sw=%0d/%0d fl=%h pad=%h last=%b"},
                                 $realtime, want.word.chan, $signed(want.word.value),
                                 want.word.sw1, want.word.sw2, want.word.flags, want.last,
                                 got.chan, $signed(got.value), got.sw1, got.sw2,
                                 got.flags, got.pad, m_axis_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: counts cycles with no word moving on either side
    // ---------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    t_frame_row rows [13];

    initial begin
        t_chan_exp  r;
        logic [7:0] hdr;
        logic [7:0] ftr;
        int         cut;
        int         pick;
        int         frames;
        int         rand_from;

        // set_cfg, centre, limit, pre, hdr, fill, flags, ftr, cut, post,
        // typed, n_out, val, sw1, sw2
        rows = '{
            // reset registers, loose words while idle, all-zero channel data
            '{0, 1024,  660, 3, 8'h0F, FILL_ZERO, 8'h00, 8'h00, 25, 0,
              1, 16,  660, SW_DOWN, SW_DOWN},
            // all channels at 2047, words after the footer ignored
            '{0, 1024,  660, 0, 8'h0F, FILL_ONES, 8'hFF, 8'h00, 25, 2,
              1, 16, -660, SW_MID,  SW_MID},
            // bad header with a good footer: dropped
            '{0, 1024,  660, 0, 8'hF0, FILL_RAND, 8'h5A, 8'h00, 25, 0,
              1,  0,    0, SW_DOWN, SW_DOWN},
            // bad footer: dropped
            '{0, 1024,  660, 0, 8'h0F, FILL_RAND, 8'h33, 8'h80, 25, 0,
              1,  0,    0, SW_DOWN, SW_DOWN},
            // abandoned in mid-frame by the next start
            '{0, 1024,  660, 0, 8'h0F, FILL_RAND, 8'h00, 8'h00, 10, 0,
              1,  0,    0, SW_DOWN, SW_DOWN},
            '{0, 1024,  660, 0, 8'h0F, FILL_RAND, 8'hF5, 8'h00, 25, 0,
              0,  0,    0, SW_DOWN, SW_DOWN},
            // restart lands where the footer would be
            '{0, 1024,  660, 0, 8'h0F, FILL_RAND, 8'hC3, 8'h00, 24, 0,
              1,  0,    0, SW_DOWN, SW_DOWN},
            '{1,    0, 1023, 0, 8'h0F, FILL_ZERO, 8'h06, 8'h00, 25, 0,
              1, 16,    0, SW_MID,  SW_UP},
            '{1,    0, 1023, 0, 8'h0F, FILL_ONES, 8'h09, 8'h00, 25, 0,
              1, 16, -1023, SW_UP,  SW_MID},
            '{1, 2047, 1023, 0, 8'h0F, FILL_ZERO, 8'h04, 8'h00, 25, 1,
              1, 16, 1023, SW_DOWN, SW_UP},
            // zero limit pins every channel to zero
            '{1, 2047,    0, 0, 8'h0F, FILL_RAND, 8'hF0, 8'h00, 25, 0,
              1, 16,    0, SW_DOWN, SW_DOWN},
            '{1, 1500, 1023, 0, 8'h0F, FILL_RAND, 8'h3C, 8'h00, 25, 0,
              0,  0,    0, SW_DOWN, SW_DOWN},
            '{1, 1024,  660, 0, 8'h0F, FILL_RAND, 8'hA3, 8'h00, 25, 1,
              0,  0,    0, SW_DOWN, SW_DOWN}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        foreach (rows[n]) begin
            if (rows[n].set_cfg) begin
                settle();
                set_config(rows[n].centre, rows[n].limit);
            end
            send_noise(rows[n].pre);
            fill_body(rows[n].fill);
            send_frame(rows[n].hdr, rows[n].flags, rows[n].ftr, rows[n].cut, !rows[n].typed);
            if (rows[n].typed) begin
                for (int c = 0; c < rows[n].n_out; c++) begin
                    r = '0;
                    r.last = (c == NUM_CH - 1);
                    r.word.chan = 4'(c);
                    r.word.value = rows[n].val;
                    r.word.sw1 = rows[n].sw1;
                    r.word.sw2 = rows[n].sw2;
                    r.word.flags = rows[n].flags;
                    chan_words_due.push_back(r);
                end
            end
            send_noise(rows[n].post);
        end

        // random frames: mostly well formed, some broken, registers moved
        // every few frames among extremes, the reset values and random values
        frames = 0;
        rand_from = words_sent;
        while (words_sent - rand_from < RANDOM_WORDS) begin
            if (frames % 4 == 3) begin
                settle();
                case ($urandom_range(0, 3))
                    0:       hdr = 8'h00;
                    default: hdr = 8'h01;
                endcase
                set_config(($urandom_range(0, 3) == 0) ? 11'd0 :
                           ($urandom_range(0, 2) == 0) ? 11'd2047 :
                           ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'($urandom),
                           ($urandom_range(0, 3) == 0) ? 10'd0 :
                           ($urandom_range(0, 2) == 0) ? 10'd1023 :
                           ($urandom_range(0, 1) == 0) ? 10'd660 : 10'($urandom));
            end
            hdr = HEADER_BYTE;
            ftr = FOOTER_BYTE;
            cut = 25;
            pick = $urandom_range(0, 99);
            if (pick >= 91) begin
                cut = $urandom_range(1, 24);
            end else if (pick >= 83) begin
                do ftr = 8'($urandom); while (ftr == FOOTER_BYTE);
            end else if (pick >= 75) begin
                do hdr = 8'($urandom); while (hdr == HEADER_BYTE);
            end
            fill_body(FILL_RAND);
            send_frame(hdr, 8'($urandom), ftr, cut, 1'b1);
            if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 3));
            frames++;
        end

        settle();
        if (bad_words == 0 && chan_words_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sbus_frame_decoder.f
src/sbusfd_pkg.sv
src/sbusfd_cell.sv
src/sbusfd_scale.sv
src/sbus_frame_decoder.sv
sim/sbus_frame_decoder_tb.sv
